FILE: sv/cwrj_pkg.sv
// shared types and constants for the cis window range join
package cwrj_pkg;

    // table geometry
    localparam int MaxMarkers = 65536;
    localparam int AddrW      = $clog2(MaxMarkers);
    localparam int CntW       = AddrW + 1;

    // field widths
    localparam int ChromW = 8;
    localparam int PosW   = 31;
    localparam int WinW   = 30;
    localparam int IdxW   = 17;

    // one table entry: chromosome id over position
    localparam int EntryW = ChromW + PosW;

    // function codes of an input word
    localparam logic FuncLoad  = 1'b0;
    localparam logic FuncQuery = 1'b1;

    // input word
    typedef struct packed {
        logic              func;
        logic [ChromW-1:0] chrom_id;
        logic [PosW-1:0]   start_pos;
        logic [PosW-1:0]   end_pos;
    } t_in;

    // result word
    typedef struct packed {
        logic            matched;
        logic [IdxW-1:0] first_index;
        logic [IdxW-1:0] last_index;
    } t_out;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

FILE: sv/cwrj_ram.sv
// generic single write port ram with registered read
module cwrj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/cis_window_range_join.sv
// top level of the cis window range join
// Marker words (func = load) are appended to a 65536-entry table while the
// block is idle; loads beyond the table size are dropped. A query word
// (func = query) walks the table forward from the kept scan pointer, one
// stored marker per cycle, set by the single read port of the marker ram.
// A query takes one walk step per marker examined (markers skipped before
// the window, the matching ones, and the one that stops the walk), and one
// more step when the walk runs off the end of the table. A query with the
// scan exhausted takes no walk step. A result word that is not taken holds
// the block in its last cycle until the output register is free. Each query
// returns one result word, each load none. The window register may be
// written at any time the block is idle.
module cis_window_range_join (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cwrj_pkg::WinW-1:0]      i_cfg_data,
    // input words
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  cwrj_pkg::t_in                  i_in_data,
    // result words
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output cwrj_pkg::t_out                 o_out_data
);

    localparam int AW = cwrj_pkg::AddrW;
    localparam int CW = cwrj_pkg::CntW;
    localparam int PW = cwrj_pkg::PosW;
    localparam int HW = PW + 1;

    cwrj_pkg::t_state r_state, n_state;

    logic [cwrj_pkg::WinW-1:0]   r_win;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_next, n_next;
    logic [CW-1:0]               r_cur, n_cur;
    logic                        r_hit, n_hit;
    logic                        r_brk, n_brk;
    logic signed [HW-1:0]        r_lo, n_lo;
    logic [HW-1:0]               r_hi, n_hi;
    logic [cwrj_pkg::ChromW-1:0] r_chrom, n_chrom;
    logic                        r_out_valid, n_out_valid;
    cwrj_pkg::t_out              r_out, n_out;

    logic                        s_in_fire;
    logic                        s_is_query;
    logic                        s_exhausted;
    logic                        s_slot_free;
    logic [CW-1:0]               s_cur_inc;
    logic                        s_in_range;
    logic                        s_chrom_ne;
    logic                        s_below;
    logic                        s_above;
    logic                        s_stop;

    logic                        s_we;
    logic [AW-1:0]               s_raddr;
    logic [cwrj_pkg::EntryW-1:0] s_rdata;
    logic [cwrj_pkg::ChromW-1:0] s_rd_chrom;
    logic [PW-1:0]               s_rd_pos;

    // marker table: chromosome id over position
    cwrj_ram #(
        .WIDTH (cwrj_pkg::EntryW),
        .DEPTH (cwrj_pkg::MaxMarkers)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_in_data.chrom_id, i_in_data.start_pos}),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign s_rd_chrom = s_rdata[cwrj_pkg::EntryW-1:PW];
    assign s_rd_pos   = s_rdata[PW-1:0];

    // handshake helpers
    assign s_in_fire   = i_in_valid && o_in_ready;
    assign s_is_query  = (i_in_data.func == cwrj_pkg::FuncQuery);
    assign s_exhausted = (r_next >= r_count);
    assign s_slot_free = !r_out_valid || i_out_ready;

    // walk step conditions for the marker at r_cur
    assign s_cur_inc  = r_cur + CW'(1);
    assign s_in_range = (r_cur < r_count);
    assign s_chrom_ne = (s_rd_chrom != r_chrom);
    assign s_below    = ($signed({1'b0, s_rd_pos}) < r_lo);
    assign s_above    = ({1'b0, s_rd_pos} > r_hi);
    assign s_stop     = !s_in_range || s_chrom_ne || (!s_below && s_above);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cwrj_pkg::ST_IDLE: begin
                if (s_in_fire && s_is_query) begin
                    n_state = s_exhausted ? cwrj_pkg::ST_DONE : cwrj_pkg::ST_WALK;
                end
            end
            cwrj_pkg::ST_WALK: begin
                if (s_stop) begin
                    n_state = cwrj_pkg::ST_DONE;
                end
            end
            cwrj_pkg::ST_DONE: begin
                if (s_slot_free) begin
                    n_state = cwrj_pkg::ST_IDLE;
                end
            end
            default: n_state = cwrj_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        unique case (r_state)
            cwrj_pkg::ST_IDLE: o_in_ready = 1'b1;
            cwrj_pkg::ST_WALK: o_in_ready = 1'b0;
            cwrj_pkg::ST_DONE: o_in_ready = 1'b0;
            default:           o_in_ready = 1'b0;
        endcase
    end

    // datapath next values
    always_comb begin
        n_count     = r_count;
        n_next      = r_next;
        n_cur       = r_cur;
        n_hit       = r_hit;
        n_brk       = r_brk;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_chrom     = r_chrom;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        s_we        = 1'b0;
        s_raddr     = r_next[AW-1:0];

        case (r_state)
            cwrj_pkg::ST_IDLE: begin
                if (s_in_fire) begin
                    if (!s_is_query) begin
                        // append a marker unless the table is full
                        if (r_count < CW'(cwrj_pkg::MaxMarkers)) begin
                            s_we    = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end else begin
                        // latch the window bounds and start the walk unless the scan is exhausted
                        n_hit   = 1'b0;
                        n_brk   = 1'b0;
                        n_cur   = r_next;
                        n_chrom = i_in_data.chrom_id;
                        n_lo    = $signed({1'b0, i_in_data.start_pos})
                                  - $signed(HW'(r_win));
                        n_hi    = {1'b0, i_in_data.end_pos} + HW'(r_win);
                    end
                end
            end
            cwrj_pkg::ST_WALK: begin
                // read ahead the following marker
                s_raddr = s_cur_inc[AW-1:0];
                if (s_in_range) begin
                    if (s_chrom_ne) begin
                        n_brk = 1'b1;
                    end else if (s_below) begin
                        n_next = s_cur_inc;
                        n_cur  = s_cur_inc;
                    end else if (!s_above) begin
                        n_hit = 1'b1;
                        n_cur = s_cur_inc;
                    end
                end
            end
            cwrj_pkg::ST_DONE: begin
                if (s_slot_free) begin
                    n_out_valid = 1'b1;
                    if (r_hit) begin
                        n_out.matched     = 1'b1;
                        n_out.first_index = cwrj_pkg::IdxW'(r_next + CW'(1));
                        n_out.last_index  = cwrj_pkg::IdxW'(r_cur);
                        // jump past the chromosome boundary
                        if (r_brk) begin
                            n_next = r_cur;
                        end
                    end else begin
                        n_out.matched     = 1'b0;
                        n_out.first_index = '0;
                        n_out.last_index  = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cwrj_pkg::ST_IDLE;
            r_count     <= '0;
            r_next      <= '0;
            r_out_valid <= 1'b0;
            r_win       <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_next      <= n_next;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_win <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_hit   <= n_hit;
        r_brk   <= n_brk;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_chrom <= n_chrom;
        r_out   <= n_out;
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sim/cis_window_range_join_checker.sv
// checker for the cis window range join: tracks the marker table, predicts and compares results
module cis_window_range_join_checker
    import cwrj_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  logic [WinW-1:0] i_cfg_data,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  t_in             i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  t_out            i_out_data,
    output int              o_fail_count,
    output int              o_pending
);

    localparam int ReportMax = 200;

    // shadow of the marker table and the scan state
    logic [ChromW-1:0] tbl_chrom [MaxMarkers];
    logic [PosW-1:0]   tbl_pos   [MaxMarkers];
    longint            marker_total = 0;
    longint            scan_base    = -1;
    longint            win_size     = 0;

    // predicted result words, oldest first
    t_out              range_q[$];
    t_out              range_exp;
    int                fail_total   = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // walk the shadow table for one gene range, moving the scan base as the block does
    function automatic t_out predict_range(input t_in w);
        t_out   r;
        longint lo;
        longint hi;
        longint cur;
        longint p;
        bit     hit;
        bit     chrom_break;
        r           = '0;
        hit         = 1'b0;
        chrom_break = 1'b0;
        if (scan_base + 1 >= marker_total) begin
            return r;
        end
        lo  = w.start_pos;
        lo  = lo - win_size;
        hi  = w.end_pos;
        hi  = hi + win_size;
        cur = scan_base + 1;
        while (cur < marker_total) begin
            if (tbl_chrom[cur] != w.chrom_id) begin
                chrom_break = 1'b1;
                break;
            end
            p = tbl_pos[cur];
            if (p < lo) begin
                scan_base = cur;
                cur++;
            end else if (p > hi) begin
                break;
            end else begin
                hit = 1'b1;
                cur++;
            end
        end
        if (hit) begin
            r.matched     = 1'b1;
            r.first_index = IdxW'(scan_base + 2);
            r.last_index  = IdxW'(cur);
            // a matched walk that ended on a new chromosome skips past the old one
            if (chrom_break) begin
                scan_base = cur - 1;
            end
        end
        return r;
    endfunction

    // one field of a result word against its prediction
    task automatic check_field(input string what, input logic [IdxW-1:0] want,
                               input logic [IdxW-1:0] got);
        if (got !== want) begin
            fail_total++;
            if (fail_total <= ReportMax) begin
                $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            end
        end
    endtask

    // watch all three channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            marker_total = 0;
            scan_base    = -1;
            win_size     = 0;
            range_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                win_size = i_cfg_data;
            end
            // compare before predicting so a stray word cannot pair with a new query
            if (i_out_valid && i_out_ready) begin
                if (range_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= ReportMax) begin
                        $display("%0t: result expected none got matched=%0d first=%0d last=%0d",
                                 $time, i_out_data.matched, i_out_data.first_index,
                                 i_out_data.last_index);
                    end
                end else begin
                    range_exp = range_q.pop_front();
                    check_field("matched", IdxW'(range_exp.matched), IdxW'(i_out_data.matched));
                    check_field("first_index", range_exp.first_index,
                                i_out_data.first_index);
                    check_field("last_index", range_exp.last_index, i_out_data.last_index);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.func == FuncLoad) begin
                    // loads past the table size are dropped
                    if (marker_total < MaxMarkers) begin
                        tbl_chrom[marker_total] = i_in_data.chrom_id;
                        tbl_pos[marker_total]   = i_in_data.start_pos;
                        marker_total++;
                    end
                end else begin
                    range_q.push_back(predict_range(i_in_data));
                end
            end
        end
        o_pending    <= range_q.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: sim/cis_window_range_join_tb.sv
// testbench top for the cis window range join: stimulus, pacing and verdict
module cis_window_range_join_tb;
    import cwrj_pkg::*;

    localparam logic [PosW-1:0] PosMax      = '1;
    localparam logic [WinW-1:0] WinMax      = '1;
    localparam int              DrainCycles = 40;
    localparam int              PhaseItems  = 350;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [WinW-1:0]   cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_in               in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out              out_data;
    int                fail_count;
    int                pending;

    // stimulus bookkeeping
    int                in_idle_pct  = 0;
    int                out_idle_pct = 0;
    int                items_sent   = 0;
    logic [ChromW-1:0] tail_chrom   = '0;

    always #1 clk = ~clk;

    cis_window_range_join u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    cis_window_range_join_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side stalls
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // clamp a wide position into the field range
    function automatic logic [PosW-1:0] to_pos(input longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > longint'(PosMax)) begin
            return PosMax;
        end
        return v[PosW-1:0];
    endfunction

    // present one input word and hold it until taken
    task automatic send_word(input t_in w);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_load(input logic [ChromW-1:0] chrom, input logic [PosW-1:0] pos);
        t_in w;
        w.func      = FuncLoad;
        w.chrom_id  = chrom;
        w.start_pos = pos;
        w.end_pos   = PosW'($urandom);
        tail_chrom  = chrom;
        send_word(w);
    endtask

    task automatic send_query(input logic [ChromW-1:0] chrom, input logic [PosW-1:0] s,
                              input logic [PosW-1:0] e);
        t_in w;
        w.func      = FuncQuery;
        w.chrom_id  = chrom;
        w.start_pos = s;
        w.end_pos   = e;
        send_word(w);
    endtask

    // stop sending, wait for every predicted word, then let a load in flight settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_window(input logic [WinW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one batch: sorted marker runs, then sorted gene ranges over them
    task automatic run_batch();
        logic [ChromW-1:0] run_chrom[$];
        longint            run_lo[$];
        longint            run_hi[$];
        logic [ChromW-1:0] prev_tail;
        logic [ChromW-1:0] c;
        longint            step_max;
        longint            spread;
        longint            pos;
        longint            gene_s;
        longint            stride;
        int                n_mark;
        int                n_gene;
        bit                wide;
        wide      = ($urandom_range(0, 1) == 1);
        step_max  = wide ? 64'd16777216 : 64'd40;
        spread    = wide ? 64'd33554432 : 64'd60;
        prev_tail = tail_chrom;
        c         = 8'($urandom_range(0, 200));
        // marker runs on ascending chromosomes, now and then one out of order
        repeat ($urandom_range(1, 3)) begin
            pos = wide ? $urandom_range(0, 32'h7000_0000) : $urandom_range(0, 3000);
            run_lo.push_back(pos);
            n_mark = $urandom_range(1, 8);
            repeat (n_mark) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_load(c, PosW'($urandom));
                end else begin
                    send_load(c, to_pos(pos));
                    pos += $urandom_range(0, 32'(step_max));
                end
            end
            run_hi.push_back(pos);
            run_chrom.push_back(c);
            c += 8'($urandom_range(1, 18));
        end
        // sweep the leftover run of the previous batch
        send_query(prev_tail, '0, PosMax);
        // gene ranges, mostly sorted, some noise
        foreach (run_chrom[k]) begin
            n_gene = $urandom_range(1, 4);
            stride = (run_hi[k] - run_lo[k] + 2 * spread) / n_gene;
            gene_s = run_lo[k] - spread;
            repeat (n_gene) begin
                gene_s += $urandom_range(0, 32'(stride));
                if ($urandom_range(0, 7) == 0) begin
                    send_query(8'($urandom), PosW'($urandom), PosW'($urandom));
                end else begin
                    send_query(run_chrom[k], to_pos(gene_s),
                               to_pos(gene_s + $urandom_range(0, 32'(spread))));
                end
            end
        end
        // sweep each run so the scan base ends inside the last one
        foreach (run_chrom[k]) begin
            send_query(run_chrom[k], '0, PosMax);
        end
    endtask

    task automatic run_phase(input int in_pct, input int out_pct, input int n_items);
        int goal;
        goal         = items_sent + n_items;
        in_idle_pct  = in_pct;
        out_idle_pct <= out_pct;
        while (items_sent < goal) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_idle();
                case ($urandom_range(0, 3))
                    0: write_window('0);
                    1: write_window(WinMax);
                    2: write_window(WinW'($urandom_range(0, 200)));
                    default: write_window(WinW'($urandom));
                endcase
            end
            run_batch();
        end
    endtask

    // main sequence
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, field extremes, chromosome breaks, reset window
        send_query(8'd5, '0, PosMax);
        send_load(8'd0, '0);
        send_load(8'd0, 31'd10);
        send_load(8'd0, PosMax);
        send_load(8'd255, '0);
        send_load(8'd255, 31'd100);
        send_load(8'd255, PosMax);
        send_query(8'd0, '0, '0);
        send_query(8'd0, 31'd5, 31'd9);
        send_query(8'd0, 31'd10, PosMax);
        send_query(8'd0, '0, PosMax);
        send_query(8'd255, PosMax, PosMax);
        send_query(8'd255, 31'd200, 31'd100);
        // load after queries keeps the scan base
        send_load(8'd255, 31'd5);
        send_query(8'd255, PosMax, '0);
        // widest window
        wait_idle();
        write_window(WinMax);
        send_query(8'd255, 31'h5000_0000, PosMax);
        send_query(8'd255, '0, '0);
        send_query(8'd255, '0, PosMax);

        // random batches under three pacing patterns
        wait_idle();
        write_window(WinW'($urandom_range(0, 200)));
        run_phase(18, 69, PhaseItems);
        wait_idle();
        write_window(WinMax);
        run_phase(69, 18, PhaseItems);
        wait_idle();
        write_window('0);
        run_phase(0, 0, PhaseItems);

        wait_idle();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit
    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
